### sv/gse_pkg.sv
// Shared constants and types for the graded safety escalation block.
package gse_pkg;

    localparam int unsigned TIME_W   = 31;
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned SEV_W    = 2;
    localparam int unsigned LEVEL_W  = 2;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 2;

    // period multiple that marks a prolonged condition
    localparam int unsigned PERIOD_FACTOR = 5;
    localparam int unsigned LIMIT_W       = PERIOD_W + 3;

    localparam logic [STAMP_W-1:0] NOT_YET   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_ACTION_EN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_ACTION_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIMING_SEV   = 2'd2;

    localparam logic [SEV_W-1:0] MIN_SEV_RESET = 2'd2;

    // requested level codes
    localparam logic [LEVEL_W-1:0] LEVEL_NONE      = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_REQUEST   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_PROLONGED = 2'd2;

    typedef logic [STAMP_W-1:0] t_stamp;

endpackage

### sv/graded_safety_escalation_top.sv
// Graded safety escalation: request grading, first-event timestamps, request counter.
// Pipeline: an accepted word passes from the input register through the compute stage
//   into the result register, which it enters once that register is empty or draining.
// Throughput: one word per cycle while the output is not stalled; the compute stage
//   updates all tracking state in the same edge that loads the result register, so back-to-back words see it.
// Reset (synchronous, active low): timestamps go to -1, the streak flag and the counter
//   to zero, config to comm/timing action off and minimum severity 2; no words held.
module graded_safety_escalation_top
    import gse_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [TIME_W-1:0]      i_time_ms,
    input  logic                   i_det_alarm,
    input  logic                   i_sample_fresh,
    input  logic                   i_timing_alarm,
    input  logic [SEV_W-1:0]       i_timing_severity,
    input  logic [PERIOD_W-1:0]    i_task_period,
    input  logic [TIME_W-1:0]      i_execution_age_ms,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_comm_alarm,
    output logic                   o_comm_request,
    output logic                   o_timing_req,
    output logic [LEVEL_W-1:0]     o_requested_level,
    output logic [COUNT_W-1:0]     o_request_count,
    output logic signed [STAMP_W-1:0] o_first_alarm_time,
    output logic signed [STAMP_W-1:0] o_first_comm_alarm_time,
    output logic signed [STAMP_W-1:0] o_first_comm_request_time,
    output logic signed [STAMP_W-1:0] o_first_timing_req_time,
    output logic signed [STAMP_W-1:0] o_first_request_time
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic             r_comm_en;
    logic             r_timing_en;
    logic [SEV_W-1:0] r_min_sev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comm_en   <= 1'b0;
            r_timing_en <= 1'b0;
            r_min_sev   <= MIN_SEV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COMM_ACTION_EN:   r_comm_en   <= i_cfg_data[0];
                CFG_TIMING_ACTION_EN: r_timing_en <= i_cfg_data[0];
                CFG_MIN_TIMING_SEV:   r_min_sev   <= i_cfg_data[SEV_W-1:0];
                default: ;  // index outside the register list: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: the input register moves into the result register whenever
    // the result register is empty or being drained this cycle.
    // ---------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic advance;
    logic accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;
            if (advance)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Input register (payload, no reset)
    // ---------------------------------------------------------------------
    logic [TIME_W-1:0]   r_time;
    logic                r_det;
    logic                r_fresh;
    logic                r_t_alarm;
    logic [SEV_W-1:0]    r_sev;
    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_age;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time    <= i_time_ms;
            r_det     <= i_det_alarm;
            r_fresh   <= i_sample_fresh;
            r_t_alarm <= i_timing_alarm;
            r_sev     <= i_timing_severity;
            r_period  <= i_task_period;
            r_age     <= i_execution_age_ms;
        end
    end

    // ---------------------------------------------------------------------
    // Tracking state. A timestamp's sign bit set means "not yet".
    // ---------------------------------------------------------------------
    logic               r_streak_on;
    logic [TIME_W-1:0]  r_streak_start;
    t_stamp             r_first_alarm;
    t_stamp             r_first_comm_alarm;
    t_stamp             r_first_comm_req;
    t_stamp             r_first_timing_req;
    t_stamp             r_first_req;
    logic [COUNT_W-1:0] r_count;

    // ---------------------------------------------------------------------
    // Compute stage
    // ---------------------------------------------------------------------
    logic               comm_alarm;
    logic               comm_req;
    logic               timing_req;
    logic [LIMIT_W-1:0] limit;
    logic [TIME_W-1:0]  streak_base;
    logic [STAMP_W-1:0] elapsed;
    logic               prolonged;
    logic [LEVEL_W-1:0] level;
    t_stamp             now_stamp;

    logic               n_streak_on;
    logic [TIME_W-1:0]  n_streak_start;
    t_stamp             n_first_alarm;
    t_stamp             n_first_comm_alarm;
    t_stamp             n_first_comm_req;
    t_stamp             n_first_timing_req;
    t_stamp             n_first_req;
    logic [COUNT_W-1:0] n_count;

    always_comb begin
        now_stamp  = {1'b0, r_time};
        comm_alarm = r_det && !r_fresh;
        comm_req   = r_comm_en && comm_alarm;
        timing_req = r_timing_en && r_t_alarm && (r_sev >= r_min_sev);

        // five periods: 4*p + p
        limit = {1'b0, r_period, 2'b00} + {3'b000, r_period};

        // a fresh streak starts at this tick, so it measures zero elapsed time
        streak_base    = r_streak_on ? r_streak_start : r_time;
        n_streak_on    = comm_alarm;
        n_streak_start = streak_base;

        // signed difference; a negative span (time going back) is never prolonged
        elapsed   = {1'b0, r_time} - {1'b0, streak_base};
        prolonged = (comm_req && !elapsed[STAMP_W-1] &&
                     (elapsed[TIME_W-1:0] >= {{(TIME_W-LIMIT_W){1'b0}}, limit})) ||
                    (timing_req && (r_age >= {{(TIME_W-LIMIT_W){1'b0}}, limit}));

        if (prolonged)
            level = LEVEL_PROLONGED;
        else if (comm_req || timing_req)
            level = LEVEL_REQUEST;
        else
            level = LEVEL_NONE;

        // latch first occurrences
        n_first_alarm      = (r_det && r_first_alarm[STAMP_W-1]) ? now_stamp : r_first_alarm;
        n_first_comm_alarm = (comm_alarm && r_first_comm_alarm[STAMP_W-1]) ?
                             now_stamp : r_first_comm_alarm;
        n_first_comm_req   = (comm_req && r_first_comm_req[STAMP_W-1]) ?
                             now_stamp : r_first_comm_req;
        n_first_timing_req = (timing_req && r_first_timing_req[STAMP_W-1]) ?
                             now_stamp : r_first_timing_req;
        n_first_req        = ((level != LEVEL_NONE) && r_first_req[STAMP_W-1]) ?
                             now_stamp : r_first_req;

        // saturate the request counter
        n_count = r_count;
        if ((level != LEVEL_NONE) && (r_count != COUNT_MAX))
            n_count = r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak_on        <= 1'b0;
            r_first_alarm      <= NOT_YET;
            r_first_comm_alarm <= NOT_YET;
            r_first_comm_req   <= NOT_YET;
            r_first_timing_req <= NOT_YET;
            r_first_req        <= NOT_YET;
            r_count            <= '0;
        end else if (advance) begin
            r_streak_on        <= n_streak_on;
            r_first_alarm      <= n_first_alarm;
            r_first_comm_alarm <= n_first_comm_alarm;
            r_first_comm_req   <= n_first_comm_req;
            r_first_timing_req <= n_first_timing_req;
            r_first_req        <= n_first_req;
            r_count            <= n_count;
        end
    end

    // streak start is only read while the streak flag is set
    always_ff @(posedge i_clk) begin
        if (advance)
            r_streak_start <= n_streak_start;
    end

    // ---------------------------------------------------------------------
    // Result register (payload, no reset)
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_comm_alarm              <= comm_alarm;
            o_comm_request            <= comm_req;
            o_timing_req              <= timing_req;
            o_requested_level         <= level;
            o_request_count           <= n_count;
            o_first_alarm_time        <= n_first_alarm;
            o_first_comm_alarm_time   <= n_first_comm_alarm;
            o_first_comm_request_time <= n_first_comm_req;
            o_first_timing_req_time   <= n_first_timing_req;
            o_first_request_time      <= n_first_req;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_prolonged_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_requested_level == LEVEL_PROLONGED)
            |-> (o_comm_request || o_timing_req))
        else $error("prolonged level without a request");

    a_request_stamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_requested_level != LEVEL_NONE)
            |-> (!o_first_request_time[STAMP_W-1] && (o_request_count != '0)))
        else $error("request word without first-request stamp or count");

    a_first_req_implies_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_first_req[STAMP_W-1] |-> (r_count != '0))
        else $error("first request latched but counter is zero");

    a_stamp_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_first_alarm[STAMP_W-1] |=> (r_first_alarm == $past(r_first_alarm)))
        else $error("first alarm stamp changed after latching");

    a_drain_never_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output drains");

endmodule
